// ===== rtl/core/gbs_pkg.sv =====
package gbs_pkg;

  // Stream field layout
  localparam int unsigned FieldW   = 16;
  localparam int unsigned InDataW  = 5 * FieldW;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned BoxCntW = 10;
  localparam logic [BoxCntW-1:0] BoxCntMax = 10'd1023;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic RegIou   = 1'b0;
  localparam logic RegScore = 1'b1;
  localparam logic [FieldW-1:0] LimitReset = 16'h8000;

  typedef struct packed {
    logic score_ok;
    logic last;
  } gbs_flags_t;

  // Packs onto the result tdata from bit 0 up
  typedef struct packed {
    logic               overflow;
    logic               keep;
    logic [BoxCntW-1:0] number;
  } gbs_verdict_t;

endpackage

// ===== rtl/core/greedy_box_suppression.sv =====
// Each request gets its verdict after a compare against every box kept so far in the
// batch; a box below the score threshold or with an empty store skips the compares.
// One box is handled at a time; its compares are issued from the single store read port
// that feeds one IoU compare per cycle through a four-stage pipeline.
// Reset: thresholds return to 0x8000, kept and box counters clear; the kept-box
// store is not cleared, entries at or above the kept count are never read.
module greedy_box_suppression #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // top_edge, left_edge, bottom_edge, right_edge, confidence (16 b each)
  input  logic [gbs_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // box_number (10 b), keep_box, store_overflow, zero pad (4 b)
  output logic [gbs_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbs_pkg::ApbAddrW-1:0]  paddr,
  input  logic [gbs_pkg::ApbDataW-1:0]  pwdata,
  output logic [gbs_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import gbs_pkg::*;

  logic [FieldW-1:0] iou_limit_q, score_limit_q;
  logic              cfg_we;

  logic                    q_valid, q_pop;
  logic [4*COORD_BITS-1:0] q_box;
  logic [2*COORD_BITS-1:0] q_area;
  gbs_flags_t              q_flags;
  gbs_verdict_t            verdict;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_limit_q   <= LimitReset;
      score_limit_q <= LimitReset;
    end else if (cfg_we) begin
      case (paddr[2])
        RegIou:   iou_limit_q   <= pwdata[FieldW-1:0];
        RegScore: score_limit_q <= pwdata[FieldW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegIou:   prdata = ApbDataW'(iou_limit_q);
      RegScore: prdata = ApbDataW'(score_limit_q);
      default:  prdata = '0;
    endcase
  end

  gbs_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_o    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .score_limit_i (score_limit_q),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_box_o       (q_box),
    .q_area_o      (q_area),
    .q_flags_o     (q_flags)
  );

  gbs_back #(
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iou_limit_i (iou_limit_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_box_i     (q_box),
    .q_area_i    (q_area),
    .q_flags_i   (q_flags),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_verdict_o (verdict),
    .m_tlast_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'(verdict);

endmodule

// ===== rtl/core/gbs_ram.sv =====
module gbs_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gbs_front.sv =====
module gbs_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [gbs_pkg::InDataW-1:0]       s_tdata_i,
  input  logic                              s_tlast_i,
  input  logic [gbs_pkg::FieldW-1:0]        score_limit_i,
  output logic                              q_valid_o,
  input  logic                              q_pop_i,
  output logic [4*COORD_BITS-1:0]           q_box_o,
  output logic [2*COORD_BITS-1:0]           q_area_o,
  output gbs_pkg::gbs_flags_t               q_flags_o
);
  import gbs_pkg::*;

  localparam int unsigned Cb    = COORD_BITS;
  localparam int unsigned BoxW  = 4 * Cb;
  localparam int unsigned AreaW = 2 * Cb;

  logic [Cb-1:0] top, left, bottom, right;
  logic [Cb-1:0] y0, x0, y1, x1;
  logic [FieldW-1:0] conf;
  logic [BoxW-1:0] box;
  logic [AreaW-1:0] area;
  gbs_flags_t flags;

  assign top    = s_tdata_i[0 +: Cb];
  assign left   = s_tdata_i[FieldW +: Cb];
  assign bottom = s_tdata_i[2*FieldW +: Cb];
  assign right  = s_tdata_i[3*FieldW +: Cb];
  assign conf   = s_tdata_i[4*FieldW +: FieldW];

  // Swapped corners are put back in order per axis
  assign y0 = (top < bottom) ? top : bottom;
  assign y1 = (top < bottom) ? bottom : top;
  assign x0 = (left < right) ? left : right;
  assign x1 = (left < right) ? right : left;

  assign box  = {y0, x0, y1, x1};
  assign area = AreaW'(x1 - x0) * AreaW'(y1 - y0);

  assign flags.score_ok = (conf >= score_limit_i);
  assign flags.last     = s_tlast_i;

  // Two-entry queue toward the compare engine
  logic [BoxW-1:0]  box_q   [2];
  logic [AreaW-1:0] area_q  [2];
  gbs_flags_t       flags_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             push;

  assign s_tready_o = (fill_q != 2'd2);
  assign q_valid_o  = (fill_q != 2'd0);
  assign push       = s_tvalid_i && s_tready_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !q_pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && q_pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      box_q[wr_ptr_q]   <= box;
      area_q[wr_ptr_q]  <= area;
      flags_q[wr_ptr_q] <= flags;
    end
  end

  assign q_box_o   = box_q[rd_ptr_q];
  assign q_area_o  = area_q[rd_ptr_q];
  assign q_flags_o = flags_q[rd_ptr_q];

endmodule

// ===== rtl/core/gbs_back.sv =====
module gbs_back #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gbs_pkg::FieldW-1:0]  iou_limit_i,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  logic [4*COORD_BITS-1:0]     q_box_i,
  input  logic [2*COORD_BITS-1:0]     q_area_i,
  input  gbs_pkg::gbs_flags_t         q_flags_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output gbs_pkg::gbs_verdict_t       m_verdict_o,
  output logic                        m_tlast_o
);
  import gbs_pkg::*;

  localparam int unsigned Cb    = COORD_BITS;
  localparam int unsigned BoxW  = 4 * Cb;
  localparam int unsigned AreaW = 2 * Cb;
  localparam int unsigned UniW  = AreaW + 1;
  localparam int unsigned ProdW = UniW + FieldW;
  localparam int unsigned CntW  = $clog2(MAX_KEPT + 1);
  localparam int unsigned AddrW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    scan_idx_q, scan_idx_d, scan_nxt;
  logic [CntW-1:0]    kept_cnt_q, kept_cnt_d;
  logic [BoxCntW-1:0] box_cnt_q, box_cnt_d;
  logic               hit_q, hit_d;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               in_flight, issue, finish, keep, full, store_we, hit_now;

  logic [BoxW-1:0]    rdata;
  logic [Cb-1:0]      sy0, sx0, sy1, sx1, cy0, cx0, cy1, cx1;
  logic [Cb-1:0]      ix0, iy0, ix1, iy1, iw, ih;
  logic [AreaW-1:0]   inter2_q, areab2_q, inter3_q;
  logic [UniW-1:0]    uni3_q;
  logic [AreaW-1:0]   inter4_q;
  logic [ProdW-1:0]   prod4_q, lhs4;
  logic               uni_nz4_q;

  logic               out_valid_q;
  gbs_verdict_t       out_verdict_q;
  logic               out_last_q;

  assign issue     = (state_q == StScan);
  assign scan_nxt  = scan_idx_q + CntW'(1);
  assign in_flight = v1_q || v2_q || v3_q || v4_q;
  assign finish    = (state_q == StDone) && (!out_valid_q || m_tready_i);
  assign keep      = q_flags_i.score_ok && !hit_q;
  assign full      = (kept_cnt_q == CntW'(MAX_KEPT));
  assign store_we  = finish && keep && !full;
  assign q_pop_o   = finish;

  gbs_ram #(
    .Width (BoxW),
    .Depth (MAX_KEPT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (kept_cnt_q[AddrW-1:0]),
    .wdata_i (q_box_i),
    .re_i    (issue),
    .raddr_i (scan_idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Stage A: overlap and stored-box area from the read data
  assign {sy0, sx0, sy1, sx1} = rdata;
  assign {cy0, cx0, cy1, cx1} = q_box_i;
  assign ix0 = (sx0 > cx0) ? sx0 : cx0;
  assign iy0 = (sy0 > cy0) ? sy0 : cy0;
  assign ix1 = (sx1 < cx1) ? sx1 : cx1;
  assign iy1 = (sy1 < cy1) ? sy1 : cy1;
  assign iw  = (ix1 > ix0) ? (ix1 - ix0) : '0;
  assign ih  = (iy1 > iy0) ? (iy1 - iy0) : '0;

  // Stage D: inter * 2^16 > limit * union
  assign lhs4    = {1'b0, inter4_q, {FieldW{1'b0}}};
  assign hit_now = v4_q && uni_nz4_q && (lhs4 > prod4_q);

  always_ff @(posedge clk_i) begin
    inter2_q  <= AreaW'(iw) * AreaW'(ih);
    areab2_q  <= AreaW'(sx1 - sx0) * AreaW'(sy1 - sy0);
    uni3_q    <= UniW'(q_area_i) + UniW'(areab2_q) - UniW'(inter2_q);
    inter3_q  <= inter2_q;
    prod4_q   <= ProdW'(iou_limit_i) * ProdW'(uni3_q);
    inter4_q  <= inter3_q;
    uni_nz4_q <= (uni3_q != '0);
  end

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    hit_d      = hit_q || hit_now;
    kept_cnt_d = kept_cnt_q;
    box_cnt_d  = box_cnt_q;
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          hit_d      = 1'b0;
          scan_idx_d = '0;
          if (q_flags_i.score_ok && (kept_cnt_q != '0)) begin
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end
      StScan: begin
        scan_idx_d = scan_nxt;
        if (scan_nxt == kept_cnt_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!in_flight) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (finish) begin
          state_d = StIdle;
          if (q_flags_i.last) begin
            kept_cnt_d = '0;
            box_cnt_d  = '0;
          end else begin
            if (store_we) begin
              kept_cnt_d = kept_cnt_q + CntW'(1);
            end
            if (box_cnt_q != BoxCntMax) begin
              box_cnt_d = box_cnt_q + BoxCntW'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_idx_q  <= '0;
      kept_cnt_q  <= '0;
      box_cnt_q   <= '0;
      hit_q       <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      kept_cnt_q <= kept_cnt_d;
      box_cnt_q  <= box_cnt_d;
      hit_q      <= hit_d;
      v1_q       <= issue;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      v4_q       <= v3_q;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_verdict_q.number   <= box_cnt_q;
      out_verdict_q.keep     <= keep;
      out_verdict_q.overflow <= keep && full;
      out_last_q             <= q_flags_i.last;
    end
  end

  assign m_tvalid_o  = out_valid_q;
  assign m_verdict_o = out_verdict_q;
  assign m_tlast_o   = out_last_q;

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (scan_idx_q < kept_cnt_q))
    else $error("scan address beyond kept count");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> !in_flight)
    else $error("verdict taken with compares still in flight");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_cnt_q <= CntW'(MAX_KEPT))
    else $error("kept count above store depth");
`endif

endmodule
